// ----- hw/rtl/pld_pkg.sv -----
package pld_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 16;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // fixed field widths of the stream payload
  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int FVAL_W   = 16;
  localparam int STATUS_W = 2;
  localparam int FCNT_W   = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_TAIL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GET        = 3'd5;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // what every cell does at each clock edge
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] at;
  } cell_ctrl_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count_next;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;
  } resp_t;

endpackage

// ----- hw/rtl/positional_list_deque.sv -----
// positional list deque: a bounded list of up to CAPACITY values kept packed
// at indices 0..count-1 in a row of cells, used as a double-ended queue.
// every request transfer carries a mode (push front/back, pop front/back,
// insert before a position, get at a position, remove at a position), a
// position and a value, and yields exactly one result transfer with a status
// (ok, bad position or empty, full), the value popped, read or removed (zero
// otherwise) and the element count after the request. all cells shift toward
// or away from the target index together in the cycle the request is
// accepted, and the result lands in an output register, so one transfer per
// cycle is sustained while the result side keeps taking. a full list refuses
// pushes and inserts with status full; an insert position past the count is
// reported bad before the full check. stored values need no reset; only the
// count and the result valid flag are cleared by rst.
module positional_list_deque (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // mode[2:0], position[8:3], item_value[24:9], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[1:0], value_out[17:2], element_count[23:18]
);
  import pld_pkg::*;

  // request fields
  logic [MODE_W-1:0]      in_mode;
  logic [POS_W-1:0]       in_pos;
  logic [FVAL_W-1:0]      in_value;
  logic [VALUE_WIDTH-1:0] ins_val;

  logic                   accept;
  logic [CNT_W-1:0]       count;
  cell_ctrl_t             dec_ctrl;
  cell_ctrl_t             cell_ctrl;
  resp_t                  resp;
  logic [VALUE_WIDTH-1:0] vals [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_val;

  // result register
  logic [STATUS_W-1:0]    out_status;
  logic [FVAL_W-1:0]      out_value;
  logic [FCNT_W-1:0]      out_count;

  assign in_mode  = s_axis_tdata[MODE_W-1:0];
  assign in_pos   = s_axis_tdata[MODE_W+POS_W-1:MODE_W];
  assign in_value = s_axis_tdata[MODE_W+POS_W+FVAL_W-1:MODE_W+POS_W];
  assign ins_val  = VALUE_WIDTH'(in_value);

  // take a new request whenever the result register is free or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pld_ctrl u_ctrl (
    .mode     (in_mode),
    .position (in_pos),
    .count    (count),
    .ctrl     (dec_ctrl),
    .resp     (resp)
  );

  // cells only move on an accepted transfer
  always_comb begin
    cell_ctrl = dec_ctrl;
    if (!accept) begin
      cell_ctrl.op = OP_HOLD;
    end
  end

  // row of cells, each talking to its left and right neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val;
    logic [VALUE_WIDTH-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = ins_val;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end
    // the last cell has no right neighbor; what it takes is past the end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end
    pld_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .idx       (IDX_W'(i)),
      .ins_val   (ins_val),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (vals[i])
    );
  end

  // single read port at the index the decoder picked (old contents)
  assign rd_val = vals[resp.rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count         <= resp.count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= resp.status;
      out_value  <= resp.rd_en ? FVAL_W'(rd_val) : '0;
      out_count  <= FCNT_W'(resp.count_next);
    end
  end

  assign m_axis_tdata = {out_count, out_value, out_status};

`ifndef SYNTH
  // the count never runs past the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  // every accepted request leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // a pending result reports the count the list actually holds
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_count == FCNT_W'(count)))
    else $error("reported count differs from stored count");

  // a full status only ever comes from a list at capacity
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status == ST_FULL)) |-> (count == CNT_W'(CAPACITY)))
    else $error("full status with room left");
`endif

endmodule

// ----- hw/rtl/pld_cell.sv -----
module pld_cell (
  input  logic                            clk,
  input  pld_pkg::cell_ctrl_t             ctrl,
  input  logic [pld_pkg::IDX_W-1:0]       idx,
  input  logic [pld_pkg::VALUE_WIDTH-1:0] ins_val,
  input  logic [pld_pkg::VALUE_WIDTH-1:0] left_val,
  input  logic [pld_pkg::VALUE_WIDTH-1:0] right_val,
  output logic [pld_pkg::VALUE_WIDTH-1:0] val
);
  import pld_pkg::*;

  logic [VALUE_WIDTH-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctrl.op)
      OP_OPEN: begin
        if (idx == ctrl.at) begin
          val_next = ins_val;
        end else if (idx > ctrl.at) begin
          val_next = left_val;
        end
      end
      OP_CLOSE: begin
        if (idx >= ctrl.at) begin
          val_next = right_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ----- hw/rtl/pld_ctrl.sv -----
module pld_ctrl (
  input  logic [pld_pkg::MODE_W-1:0] mode,
  input  logic [pld_pkg::POS_W-1:0]  position,
  input  logic [pld_pkg::CNT_W-1:0]  count,
  output pld_pkg::cell_ctrl_t        ctrl,
  output pld_pkg::resp_t             resp
);
  import pld_pkg::*;

  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign full    = (count >= CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count);
  assign cnt_inc = CNT_W'(count + 1'b1);
  assign cnt_dec = CNT_W'(count - 1'b1);

  always_comb begin
    ctrl.op         = OP_HOLD;
    ctrl.at         = '0;
    resp.status     = ST_OK;
    resp.count_next = count;
    resp.rd_en      = 1'b0;
    resp.rd_idx     = '0;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_TAIL: begin
        if (full) begin
          resp.status = ST_FULL;
        end else begin
          ctrl.op         = OP_OPEN;
          ctrl.at         = (mode == MODE_PUSH_FRONT) ? '0 : IDX_W'(count);
          resp.count_next = cnt_inc;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (empty) begin
          resp.status = ST_BAD;
        end else begin
          ctrl.op         = OP_CLOSE;
          ctrl.at         = (mode == MODE_POP_FRONT) ? '0 : IDX_W'(cnt_dec);
          resp.rd_en      = 1'b1;
          resp.rd_idx     = ctrl.at;
          resp.count_next = cnt_dec;
        end
      end
      MODE_INSERT: begin
        if (pos_ext > cnt_ext) begin
          resp.status = ST_BAD;
        end else if (full) begin
          resp.status = ST_FULL;
        end else begin
          ctrl.op         = OP_OPEN;
          ctrl.at         = IDX_W'(position);
          resp.count_next = cnt_inc;
        end
      end
      MODE_GET, MODE_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          resp.status = ST_BAD;
        end else begin
          resp.rd_en  = 1'b1;
          resp.rd_idx = IDX_W'(position);
          if (mode == MODE_REMOVE) begin
            ctrl.op         = OP_CLOSE;
            ctrl.at         = IDX_W'(position);
            resp.count_next = cnt_dec;
          end
        end
      end
      default: resp.status = ST_BAD;
    endcase
  end

endmodule
